FILE: hdl/mct_pkg.sv
// shared types, constants and codes of the mesh convexity test
// no dependencies; used by every module of the block
`default_nettype none

package mct_pkg;

    localparam int MAX_VERTICES_DEF  = 256;
    localparam int MAX_TRIANGLES_DEF = 512;

    localparam int COORD_W = 16;   // q8.8 coordinate
    localparam int IDX_W   = 8;    // corner index
    localparam int TOL_W   = 8;
    localparam int TSQ_W   = 2 * TOL_W;
    localparam int DIFF_W  = COORD_W + 1;   // edge vector component
    localparam int NRM_W   = 34;            // raw normal component, signed
    localparam int DOT_W   = 52;            // plane distance numerator, signed
    localparam int N2_W    = 68;            // squared normal length
    localparam int LIM_W   = N2_W + TSQ_W;  // tolerance limit
    localparam int MA_W    = 68;            // multiplicand
    localparam int MB_W    = 51;            // multiplier, walked one bit a cycle
    localparam int MP_W    = MA_W + MB_W;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;

    typedef enum logic [1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_EVAL     = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_OVF   = 2'd1,
        FLT_INDEX = 2'd2
    } t_fault;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [IDX_W-1:0]          corner_a;
        logic [IDX_W-1:0]          corner_b;
        logic [IDX_W-1:0]          corner_c;
    } t_req;

    typedef struct packed {
        logic       is_convex;
        logic [1:0] fault;
    } t_resp;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vtx;

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } t_tri;

    // multiplier operations in the order the sequencer issues them
    typedef enum logic [3:0] {
        MOP_X0P  = 4'd0,
        MOP_X0M  = 4'd1,
        MOP_X1P  = 4'd2,
        MOP_X1M  = 4'd3,
        MOP_X2P  = 4'd4,
        MOP_X2M  = 4'd5,
        MOP_NSQ0 = 4'd6,
        MOP_NSQ1 = 4'd7,
        MOP_NSQ2 = 4'd8,
        MOP_LIM  = 4'd9,
        MOP_DOT0 = 4'd10,
        MOP_DOT1 = 4'd11,
        MOP_DOT2 = 4'd12,
        MOP_DSQ  = 4'd13
    } t_mop;

    typedef enum logic [1:0] {
        VSEL_A = 2'd0,
        VSEL_B = 2'd1,
        VSEL_C = 2'd2,
        VSEL_M = 2'd3
    } t_vsel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EVAL,
        S_CHK_RD,
        S_CHK_TST,
        S_TRI_RD,
        S_TRI_TST,
        S_VA_RD,
        S_VA_CAP,
        S_VB_CAP,
        S_VC_CAP,
        S_NRM_GO,
        S_NRM_WAIT,
        S_M_TST,
        S_M_CAP,
        S_DOT_GO,
        S_DOT_WAIT,
        S_DECIDE,
        S_DSQ_GO,
        S_DSQ_WAIT,
        S_JUDGE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       load_v;
        logic       load_t;
        logic       t_clr;
        logic       t_inc;
        logic       m_clr;
        logic       m_inc;
        t_vsel      vsel;
        logic       cap_tri;
        logic       cap_a;
        logic       cap_b;
        logic       cap_c;
        logic       cap_m;
        logic       mul_start;
        t_mop       mop;
        logic       ref_load;
        logic       ref_clr;
        logic       res_load;
        logic       res_convex;
        logic [1:0] res_fault;
        logic       clear_mesh;
    } t_cmd;

    typedef struct packed {
        logic ovf;
        logic t_end;
        logic t_none;
        logic tri_bad;
        logic m_end;
        logic m_skip;
        logic mul_done;
        logic sum_zero;
        logic sum_pos;
        logic ref_set;
        logic ref_pos;
        logic far;
        logic res_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: hdl/mct_mult.sv
// shift-and-add multiplier, one multiplier bit per cycle, stops when the bits run out
// depends on mct_pkg for operand widths
`default_nettype none

module mct_mult (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [mct_pkg::MA_W-1:0] i_a,
    input  wire logic [mct_pkg::MB_W-1:0] i_b,
    output logic                          o_done,
    output logic [mct_pkg::MP_W-1:0]      o_prod
);

    logic                     r_busy;
    logic                     r_done;
    logic [mct_pkg::MP_W-1:0] r_a;
    logic [mct_pkg::MB_W-1:0] r_b;
    logic [mct_pkg::MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_b == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= mct_pkg::MP_W'(i_a);
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy && (r_b != '0)) begin
            r_p <= r_p + (r_b[0] ? r_a : '0);
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

`default_nettype wire

FILE: hdl/mct_datapath.sv
// datapath: vertex and triangle stores, counts, edge and normal registers,
// shared multiplier, result register; depends on mct_pkg and mct_mult
`default_nettype none

module mct_datapath #(
    parameter int MAX_VERTICES  = mct_pkg::MAX_VERTICES_DEF,
    parameter int MAX_TRIANGLES = mct_pkg::MAX_TRIANGLES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire mct_pkg::t_req             i_req,
    input  wire logic                      i_cfg_we,
    input  wire logic [mct_pkg::TOL_W-1:0] i_cfg_data,
    input  wire mct_pkg::t_cmd             i_cmd,
    output mct_pkg::t_sts                  o_sts,
    output logic                           o_resp_valid,
    input  wire logic                      i_resp_stall,
    output mct_pkg::t_resp                 o_resp
);

    localparam int VA  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int TA  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int TCW = $clog2(MAX_TRIANGLES + 1);

    localparam int DIFF_W = mct_pkg::DIFF_W;
    localparam int NRM_W  = mct_pkg::NRM_W;
    localparam int DOT_W  = mct_pkg::DOT_W;
    localparam int MA_W   = mct_pkg::MA_W;
    localparam int MB_W   = mct_pkg::MB_W;
    localparam int MP_W   = mct_pkg::MP_W;

    function automatic logic signed [DIFF_W-1:0] vdiff(
        input logic signed [mct_pkg::COORD_W-1:0] p,
        input logic signed [mct_pkg::COORD_W-1:0] q
    );
        return DIFF_W'(p) - DIFF_W'(q);
    endfunction

    function automatic logic [DOT_W-1:0] mag_of(input logic signed [DOT_W-1:0] v);
        return v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
    endfunction

    mct_pkg::t_vtx r_vmem [MAX_VERTICES];
    mct_pkg::t_tri r_tmem [MAX_TRIANGLES];
    mct_pkg::t_vtx r_vrd;
    mct_pkg::t_tri r_trd;

    logic [VCW-1:0]               r_vcount;
    logic [TCW-1:0]               r_tcount;
    logic                         r_ovf;
    logic [mct_pkg::TOL_W-1:0]    r_tol;
    logic [TCW-1:0]               r_t;
    logic [VCW-1:0]               r_m;
    logic                         r_ref_set;
    logic                         r_ref_pos;
    logic                         r_ov;
    mct_pkg::t_resp               r_resp;

    mct_pkg::t_tri                r_cur;
    mct_pkg::t_vtx                r_va;
    logic signed [DIFF_W-1:0]     r_ab [3];
    logic signed [DIFF_W-1:0]     r_ac [3];
    logic signed [DIFF_W-1:0]     r_am [3];
    logic signed [NRM_W-1:0]      r_n  [3];
    logic signed [DOT_W-1:0]      r_sum;
    logic [mct_pkg::N2_W-1:0]     r_n2;
    logic [mct_pkg::LIM_W-1:0]    r_lim;
    logic                         r_far;
    mct_pkg::t_mop                r_mop;
    logic                         r_neg;

    logic [VA-1:0]                vaddr;
    logic                         v_we;
    logic                         t_we;
    logic [MA_W-1:0]              op_a;
    logic [MB_W-1:0]              op_b;
    logic                         op_neg;
    logic                         mul_done;
    logic [MP_W-1:0]              prod;
    logic [DOT_W-1:0]             plo;
    logic signed [DOT_W-1:0]      sv;
    logic signed [DOT_W-1:0]      nrm_diff;
    logic [mct_pkg::TSQ_W-1:0]    tolsq;
    logic                         res_free;

    assign v_we  = i_cmd.load_v && (r_vcount != VCW'(MAX_VERTICES));
    assign t_we  = i_cmd.load_t && (r_tcount != TCW'(MAX_TRIANGLES));
    assign tolsq = r_tol * r_tol;

    always_comb begin
        case (i_cmd.vsel)
            mct_pkg::VSEL_A: vaddr = VA'(r_cur.a);
            mct_pkg::VSEL_B: vaddr = VA'(r_cur.b);
            mct_pkg::VSEL_C: vaddr = VA'(r_cur.c);
            mct_pkg::VSEL_M: vaddr = r_m[VA-1:0];
            default:         vaddr = r_m[VA-1:0];
        endcase
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[r_vcount[VA-1:0]] <= {i_req.coord_x, i_req.coord_y, i_req.coord_z};
        end
        r_vrd <= r_vmem[vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[r_tcount[TA-1:0]] <= {i_req.corner_a, i_req.corner_b, i_req.corner_c};
        end
        r_trd <= r_tmem[r_t[TA-1:0]];
    end

    // operand select for the shared multiplier
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        case (i_cmd.mop)
            mct_pkg::MOP_X0P: begin
                op_a   = MA_W'(mag_of(DOT_W'(r_ab[1])));
                op_b   = MB_W'(mag_of(DOT_W'(r_ac[2])));
                op_neg = r_ab[1][DIFF_W-1] ^ r_ac[2][DIFF_W-1];
            end
            mct_pkg::MOP_X0M: begin
                op_a   = MA_W'(mag_of(DOT_W'(r_ab[2])));
                op_b   = MB_W'(mag_of(DOT_W'(r_ac[1])));
                op_neg = r_ab[2][DIFF_W-1] ^ r_ac[1][DIFF_W-1];
            end
            mct_pkg::MOP_X1P: begin
                op_a   = MA_W'(mag_of(DOT_W'(r_ab[2])));
                op_b   = MB_W'(mag_of(DOT_W'(r_ac[0])));
                op_neg = r_ab[2][DIFF_W-1] ^ r_ac[0][DIFF_W-1];
            end
            mct_pkg::MOP_X1M: begin
                op_a   = MA_W'(mag_of(DOT_W'(r_ab[0])));
                op_b   = MB_W'(mag_of(DOT_W'(r_ac[2])));
                op_neg = r_ab[0][DIFF_W-1] ^ r_ac[2][DIFF_W-1];
            end
            mct_pkg::MOP_X2P: begin
                op_a   = MA_W'(mag_of(DOT_W'(r_ab[0])));
                op_b   = MB_W'(mag_of(DOT_W'(r_ac[1])));
                op_neg = r_ab[0][DIFF_W-1] ^ r_ac[1][DIFF_W-1];
            end
            mct_pkg::MOP_X2M: begin
                op_a   = MA_W'(mag_of(DOT_W'(r_ab[1])));
                op_b   = MB_W'(mag_of(DOT_W'(r_ac[0])));
                op_neg = r_ab[1][DIFF_W-1] ^ r_ac[0][DIFF_W-1];
            end
            mct_pkg::MOP_NSQ0: begin
                op_a = MA_W'(mag_of(DOT_W'(r_n[0])));
                op_b = MB_W'(mag_of(DOT_W'(r_n[0])));
            end
            mct_pkg::MOP_NSQ1: begin
                op_a = MA_W'(mag_of(DOT_W'(r_n[1])));
                op_b = MB_W'(mag_of(DOT_W'(r_n[1])));
            end
            mct_pkg::MOP_NSQ2: begin
                op_a = MA_W'(mag_of(DOT_W'(r_n[2])));
                op_b = MB_W'(mag_of(DOT_W'(r_n[2])));
            end
            mct_pkg::MOP_LIM: begin
                op_a = r_n2;
                op_b = MB_W'(tolsq);
            end
            mct_pkg::MOP_DOT0: begin
                op_a   = MA_W'(mag_of(DOT_W'(r_n[0])));
                op_b   = MB_W'(mag_of(DOT_W'(r_am[0])));
                op_neg = r_n[0][NRM_W-1] ^ r_am[0][DIFF_W-1];
            end
            mct_pkg::MOP_DOT1: begin
                op_a   = MA_W'(mag_of(DOT_W'(r_n[1])));
                op_b   = MB_W'(mag_of(DOT_W'(r_am[1])));
                op_neg = r_n[1][NRM_W-1] ^ r_am[1][DIFF_W-1];
            end
            mct_pkg::MOP_DOT2: begin
                op_a   = MA_W'(mag_of(DOT_W'(r_n[2])));
                op_b   = MB_W'(mag_of(DOT_W'(r_am[2])));
                op_neg = r_n[2][NRM_W-1] ^ r_am[2][DIFF_W-1];
            end
            mct_pkg::MOP_DSQ: begin
                op_a = MA_W'(mag_of(r_sum));
                op_b = MB_W'(mag_of(r_sum));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    mct_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    assign plo      = prod[DOT_W-1:0];
    assign sv       = r_neg ? (~plo + DOT_W'(1)) : plo;
    assign nrm_diff = r_sum - sv;
    assign res_free = !r_ov || !i_resp_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount  <= '0;
            r_tcount  <= '0;
            r_ovf     <= 1'b0;
            r_tol     <= mct_pkg::TOL_RESET;
            r_t       <= '0;
            r_m       <= '0;
            r_ref_set <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (i_cmd.clear_mesh) begin
                r_vcount <= '0;
                r_tcount <= '0;
                r_ovf    <= 1'b0;
            end else begin
                if (i_cmd.load_v) begin
                    if (v_we) r_vcount <= r_vcount + VCW'(1);
                    else      r_ovf    <= 1'b1;
                end
                if (i_cmd.load_t) begin
                    if (t_we) r_tcount <= r_tcount + TCW'(1);
                    else      r_ovf    <= 1'b1;
                end
            end
            if (i_cmd.t_clr)      r_t <= '0;
            else if (i_cmd.t_inc) r_t <= r_t + TCW'(1);
            if (i_cmd.m_clr)      r_m <= '0;
            else if (i_cmd.m_inc) r_m <= r_m + VCW'(1);
            if (i_cmd.ref_clr)       r_ref_set <= 1'b0;
            else if (i_cmd.ref_load) r_ref_set <= (r_sum != '0);
            if (i_cmd.res_load)   r_ov <= 1'b1;
            else if (res_free)    r_ov <= 1'b0;
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_tri) r_cur <= r_trd;
        if (i_cmd.cap_a)   r_va  <= r_vrd;
        if (i_cmd.cap_b) begin
            r_ab[0] <= vdiff(r_vrd.x, r_va.x);
            r_ab[1] <= vdiff(r_vrd.y, r_va.y);
            r_ab[2] <= vdiff(r_vrd.z, r_va.z);
        end
        if (i_cmd.cap_c) begin
            r_ac[0] <= vdiff(r_vrd.x, r_va.x);
            r_ac[1] <= vdiff(r_vrd.y, r_va.y);
            r_ac[2] <= vdiff(r_vrd.z, r_va.z);
        end
        if (i_cmd.cap_m) begin
            r_am[0] <= vdiff(r_vrd.x, r_va.x);
            r_am[1] <= vdiff(r_vrd.y, r_va.y);
            r_am[2] <= vdiff(r_vrd.z, r_va.z);
        end
        if (i_cmd.ref_load) r_ref_pos <= !r_sum[DOT_W-1] && (r_sum != '0);
        if (i_cmd.mul_start) begin
            r_mop <= i_cmd.mop;
            r_neg <= op_neg;
        end
        if (mul_done) begin
            case (r_mop)
                mct_pkg::MOP_X0P,
                mct_pkg::MOP_X1P,
                mct_pkg::MOP_X2P,
                mct_pkg::MOP_DOT0: r_sum  <= sv;
                mct_pkg::MOP_X0M:  r_n[0] <= nrm_diff[NRM_W-1:0];
                mct_pkg::MOP_X1M:  r_n[1] <= nrm_diff[NRM_W-1:0];
                mct_pkg::MOP_X2M:  r_n[2] <= nrm_diff[NRM_W-1:0];
                mct_pkg::MOP_NSQ0: r_n2   <= prod[mct_pkg::N2_W-1:0];
                mct_pkg::MOP_NSQ1,
                mct_pkg::MOP_NSQ2: r_n2   <= r_n2 + prod[mct_pkg::N2_W-1:0];
                mct_pkg::MOP_LIM:  r_lim  <= prod[mct_pkg::LIM_W-1:0];
                mct_pkg::MOP_DOT1,
                mct_pkg::MOP_DOT2: r_sum  <= r_sum + sv;
                mct_pkg::MOP_DSQ:  r_far  <= !(prod < MP_W'(r_lim));
                default:           r_far  <= r_far;
            endcase
        end
        if (i_cmd.res_load) begin
            r_resp.is_convex <= i_cmd.res_convex;
            r_resp.fault     <= i_cmd.res_fault;
        end
    end

    always_comb begin
        o_sts.ovf      = r_ovf;
        o_sts.t_end    = (r_t == r_tcount);
        o_sts.t_none   = (r_tcount == '0);
        o_sts.tri_bad  = (32'(r_trd.a) >= 32'(r_vcount)) ||
                         (32'(r_trd.b) >= 32'(r_vcount)) ||
                         (32'(r_trd.c) >= 32'(r_vcount));
        o_sts.m_end    = (r_m == r_vcount);
        o_sts.m_skip   = (32'(r_m) == 32'(r_cur.a)) || (32'(r_m) == 32'(r_cur.b)) ||
                         (32'(r_m) == 32'(r_cur.c));
        o_sts.mul_done = mul_done;
        o_sts.sum_zero = (r_sum == '0);
        o_sts.sum_pos  = !r_sum[DOT_W-1] && (r_sum != '0);
        o_sts.ref_set  = r_ref_set;
        o_sts.ref_pos  = r_ref_pos;
        o_sts.far      = r_far;
        o_sts.res_free = res_free;
    end

    assign o_resp_valid = r_ov;
    assign o_resp       = r_resp;

endmodule

`default_nettype wire

FILE: hdl/mct_ctrl.sv
// controller state machine: request handshake, index check, per-triangle walk
// depends on mct_pkg; drives the datapath through t_cmd and reads t_sts
`default_nettype none

module mct_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    input  wire logic [1:0]    i_kind,
    input  wire mct_pkg::t_sts i_sts,
    output mct_pkg::t_cmd      o_cmd,
    output logic               o_req_stall
);

    mct_pkg::t_state r_state, n_state;
    mct_pkg::t_mop   r_mop, n_mop;
    logic            r_convex, n_convex;
    logic [1:0]      r_fault, n_fault;
    logic            accept;

    assign accept = i_req_valid && (r_state == mct_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mct_pkg::S_IDLE;
            r_mop    <= mct_pkg::MOP_X0P;
            r_convex <= 1'b0;
            r_fault  <= mct_pkg::FLT_NONE;
        end else begin
            r_state  <= n_state;
            r_mop    <= n_mop;
            r_convex <= n_convex;
            r_fault  <= n_fault;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_mop    = r_mop;
        n_convex = r_convex;
        n_fault  = r_fault;
        case (r_state)
            mct_pkg::S_IDLE: begin
                if (accept && (i_kind == mct_pkg::KIND_EVAL)) n_state = mct_pkg::S_EVAL;
            end
            mct_pkg::S_EVAL: begin
                n_convex = 1'b0;
                n_fault  = mct_pkg::FLT_NONE;
                if (i_sts.ovf) begin
                    n_fault = mct_pkg::FLT_OVF;
                    n_state = mct_pkg::S_FIN;
                end else begin
                    n_state = mct_pkg::S_CHK_RD;
                end
            end
            mct_pkg::S_CHK_RD: n_state = mct_pkg::S_CHK_TST;
            mct_pkg::S_CHK_TST: begin
                if (i_sts.t_end) begin
                    n_state = i_sts.t_none ? mct_pkg::S_FIN : mct_pkg::S_TRI_RD;
                end else if (i_sts.tri_bad) begin
                    n_fault = mct_pkg::FLT_INDEX;
                    n_state = mct_pkg::S_FIN;
                end else begin
                    n_state = mct_pkg::S_CHK_RD;
                end
            end
            mct_pkg::S_TRI_RD: n_state = mct_pkg::S_TRI_TST;
            mct_pkg::S_TRI_TST: begin
                if (i_sts.t_end) begin
                    n_convex = 1'b1;
                    n_state  = mct_pkg::S_FIN;
                end else begin
                    n_state = mct_pkg::S_VA_RD;
                end
            end
            mct_pkg::S_VA_RD:  n_state = mct_pkg::S_VA_CAP;
            mct_pkg::S_VA_CAP: n_state = mct_pkg::S_VB_CAP;
            mct_pkg::S_VB_CAP: n_state = mct_pkg::S_VC_CAP;
            mct_pkg::S_VC_CAP: begin
                n_mop   = mct_pkg::MOP_X0P;
                n_state = mct_pkg::S_NRM_GO;
            end
            mct_pkg::S_NRM_GO: n_state = mct_pkg::S_NRM_WAIT;
            mct_pkg::S_NRM_WAIT: begin
                if (i_sts.mul_done) begin
                    if (r_mop == mct_pkg::MOP_LIM) begin
                        n_state = mct_pkg::S_M_TST;
                    end else begin
                        n_mop   = mct_pkg::t_mop'(r_mop + 4'd1);
                        n_state = mct_pkg::S_NRM_GO;
                    end
                end
            end
            mct_pkg::S_M_TST: begin
                if (i_sts.m_end)       n_state = mct_pkg::S_TRI_RD;
                else if (!i_sts.m_skip) n_state = mct_pkg::S_M_CAP;
            end
            mct_pkg::S_M_CAP: begin
                n_mop   = mct_pkg::MOP_DOT0;
                n_state = mct_pkg::S_DOT_GO;
            end
            mct_pkg::S_DOT_GO: n_state = mct_pkg::S_DOT_WAIT;
            mct_pkg::S_DOT_WAIT: begin
                if (i_sts.mul_done) begin
                    if (r_mop == mct_pkg::MOP_DOT2) begin
                        n_state = mct_pkg::S_DECIDE;
                    end else begin
                        n_mop   = mct_pkg::t_mop'(r_mop + 4'd1);
                        n_state = mct_pkg::S_DOT_GO;
                    end
                end
            end
            mct_pkg::S_DECIDE: begin
                if (!i_sts.ref_set || i_sts.sum_zero) begin
                    n_state = mct_pkg::S_M_TST;
                end else begin
                    n_mop   = mct_pkg::MOP_DSQ;
                    n_state = mct_pkg::S_DSQ_GO;
                end
            end
            mct_pkg::S_DSQ_GO: n_state = mct_pkg::S_DSQ_WAIT;
            mct_pkg::S_DSQ_WAIT: begin
                if (i_sts.mul_done) n_state = mct_pkg::S_JUDGE;
            end
            mct_pkg::S_JUDGE: begin
                if (i_sts.far && (i_sts.sum_pos != i_sts.ref_pos)) begin
                    n_convex = 1'b0;
                    n_state  = mct_pkg::S_FIN;
                end else begin
                    n_state = mct_pkg::S_M_TST;
                end
            end
            mct_pkg::S_FIN: begin
                if (i_sts.res_free) n_state = mct_pkg::S_IDLE;
            end
            default: n_state = mct_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.vsel       = mct_pkg::VSEL_M;
        o_cmd.mop        = r_mop;
        o_cmd.res_convex = r_convex;
        o_cmd.res_fault  = r_fault;
        o_req_stall      = (r_state != mct_pkg::S_IDLE);
        case (r_state)
            mct_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        mct_pkg::KIND_VERTEX:   o_cmd.load_v = 1'b1;
                        mct_pkg::KIND_TRIANGLE: o_cmd.load_t = 1'b1;
                        default:                o_cmd.load_v = 1'b0;
                    endcase
                end
            end
            mct_pkg::S_EVAL:    o_cmd.t_clr = 1'b1;
            mct_pkg::S_CHK_TST: begin
                if (i_sts.t_end)         o_cmd.t_clr = 1'b1;
                else if (!i_sts.tri_bad) o_cmd.t_inc = 1'b1;
            end
            mct_pkg::S_TRI_TST: o_cmd.cap_tri = !i_sts.t_end;
            mct_pkg::S_VA_RD:   o_cmd.vsel = mct_pkg::VSEL_A;
            mct_pkg::S_VA_CAP: begin
                o_cmd.cap_a = 1'b1;
                o_cmd.vsel  = mct_pkg::VSEL_B;
            end
            mct_pkg::S_VB_CAP: begin
                o_cmd.cap_b = 1'b1;
                o_cmd.vsel  = mct_pkg::VSEL_C;
            end
            mct_pkg::S_VC_CAP: o_cmd.cap_c = 1'b1;
            mct_pkg::S_NRM_GO,
            mct_pkg::S_DOT_GO,
            mct_pkg::S_DSQ_GO: o_cmd.mul_start = 1'b1;
            mct_pkg::S_NRM_WAIT: begin
                if (i_sts.mul_done && (r_mop == mct_pkg::MOP_LIM)) begin
                    o_cmd.ref_clr = 1'b1;
                    o_cmd.m_clr   = 1'b1;
                end
            end
            mct_pkg::S_M_TST: begin
                if (i_sts.m_end)       o_cmd.t_inc = 1'b1;
                else if (i_sts.m_skip) o_cmd.m_inc = 1'b1;
                else                   o_cmd.vsel  = mct_pkg::VSEL_M;
            end
            mct_pkg::S_M_CAP: o_cmd.cap_m = 1'b1;
            mct_pkg::S_DECIDE: begin
                if (!i_sts.ref_set) begin
                    o_cmd.ref_load = 1'b1;
                    o_cmd.m_inc    = 1'b1;
                end else if (i_sts.sum_zero) begin
                    o_cmd.m_inc = 1'b1;
                end
            end
            mct_pkg::S_JUDGE: begin
                if (!(i_sts.far && (i_sts.sum_pos != i_sts.ref_pos))) o_cmd.m_inc = 1'b1;
            end
            mct_pkg::S_FIN: begin
                o_cmd.res_load   = i_sts.res_free;
                o_cmd.clear_mesh = i_sts.res_free;
            end
            default: o_cmd.vsel = mct_pkg::VSEL_M;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/mesh_convexity_test.sv
// loads: one request per cycle, no result. evaluate: an index check over the triangles, then per
// triangle ten setup multiplies, and per other vertex three dot-product multiplies and at most
// one squaring; each multiply walks the bits of its second operand on the single shift-and-add
// multiplier shared by every product
// reset (synchronous, active low) clears counts, overflow flag and result valid and sets
// tolerance to 3; the stores are not cleared and are used only below the counts
`default_nettype none

module mesh_convexity_test #(
    parameter int MAX_VERTICES  = mct_pkg::MAX_VERTICES_DEF,
    parameter int MAX_TRIANGLES = mct_pkg::MAX_TRIANGLES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // request channel
    input  wire logic                      i_req_valid,
    output logic                           o_req_stall,
    input  wire mct_pkg::t_req             i_req,
    // result channel
    output logic                           o_resp_valid,
    input  wire logic                      i_resp_stall,
    output mct_pkg::t_resp                 o_resp,
    // tolerance register write
    input  wire logic                      i_cfg_we,
    input  wire logic [mct_pkg::TOL_W-1:0] i_cfg_data
);

    mct_pkg::t_cmd cmd;
    mct_pkg::t_sts sts;

    // sequencer: accepts requests in idle, walks triangles and vertices on evaluate
    mct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_kind      (i_req.kind),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall)
    );

    // stores, normal and plane arithmetic, result register
    mct_datapath #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_resp_valid (o_resp_valid),
        .i_resp_stall (i_resp_stall),
        .o_resp       (o_resp)
    );

    // an accepted evaluate holds off the next request
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall && (i_req.kind == mct_pkg::KIND_EVAL)) |=> o_req_stall)
        else $error("evaluate accepted but request channel not stalled");

    // a faulted result never reports convex
    a_fault_not_convex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_valid && (o_resp.fault != mct_pkg::FLT_NONE)) |-> !o_resp.is_convex)
        else $error("fault reported with convex set");

    // a new result only appears at the end of an evaluate
    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_resp_valid) |-> $past(o_req_stall))
        else $error("result appeared outside an evaluate");

endmodule

`default_nettype wire
